// File: sv/assert_macros.svh
// ============================================================================
// Assertion macros
// Shared concurrent assertion forms used by the checker modules.
// ============================================================================
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is low.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that is also checked while reset is applied.
`define ASSERT_ALWAYS(name, clk, prop, msg) \
    name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// File: sv/slrg_pkg.sv
// ============================================================================
// slrg_pkg
// Types, constants and command structures of the shuffled Lehmer generator.
// ============================================================================
package slrg_pkg;

    // Shuffle table geometry. The slot of a draw is the top bits of the last
    // output, which divides by 2^26 for a depth of 32.
    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int VAL_W       = 31;
    localparam int SLOT_SHIFT  = VAL_W - IDX_W;

    // Warm-up runs eight steps ahead of the table fill.
    localparam int FILL_STEPS  = TABLE_DEPTH + 8;
    localparam int CNT_W       = $clog2(FILL_STEPS);

    // Lehmer constants: multiplier 16807, modulus 2^31-1.
    localparam int MUL_W = 15;
    localparam int PROD_W = VAL_W + MUL_W;
    localparam logic [VAL_W-1:0] LEH_M = 31'h7FFF_FFFF;
    localparam logic [MUL_W-1:0] LEH_A = 15'd16807;

    // Low Q16 part of the scaled span: 0.9999 for a positive span, and the
    // remainder of its magnitude for a negative span.
    localparam logic [15:0] LO_POS = 16'd65529;
    localparam logic [15:0] LO_NEG = 16'd7;

    // Register file of the configuration port.
    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-3:0] REG_SEED = 1'b0;

    // Request and result payloads.
    typedef struct packed {
        logic               mode;
        logic signed [31:0] range_min;
        logic signed [31:0] range_max;
    } t_req;

    typedef struct packed {
        logic [VAL_W-1:0]   unit_value;
        logic signed [31:0] ranged_value;
    } t_rsp;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic             capture;
        logic             load_start;
        logic             use_one;
        logic             step_mul;
        logic             step_red;
        logic             fill_wr;
        logic             set_last;
        logic [IDX_W-1:0] fill_idx;
        logic             draw_rd;
        logic             draw_wr;
        logic             sc_mul;
        logic             sc_sum;
        logic             sc_fold;
        logic             sc_quot;
        logic             out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic state_zero;
        logic last_zero;
    } t_dp_sts;

    // Controller states.
    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_CHECK = 11'b000_0000_0010,
        S_FMUL  = 11'b000_0000_0100,
        S_FRED  = 11'b000_0000_1000,
        S_DRD   = 11'b000_0001_0000,
        S_DWR   = 11'b000_0010_0000,
        S_M1    = 11'b000_0100_0000,
        S_M2    = 11'b000_1000_0000,
        S_M3    = 11'b001_0000_0000,
        S_M4    = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

endpackage

// File: sv/shuffled_lehmer_random_generator.sv
// ============================================================================
// shuffled_lehmer_random_generator
// Minimal-standard Lehmer generator with a Bays-Durham shuffle table.
// ============================================================================
// Usage:
// A request transfer on the input channel carries mode, range_min and
// range_max. Each request yields one result transfer with the shuffled unit
// value and, in mode 1, min + floor((max - min + 0.9999) * value/(2^31-1)).
// The seed register is to be written over the APB port only while the block
// is idle; the block does not enforce this. An ordinary request has its
// result offered after the zero check, the shuffled draw through the serial
// Lehmer step unit (multiply, then modular fold) and the four-stage scaler.
// The input is ready again from that same cycle, so requests are served one
// at a time. After reset or a seed write the next request first runs 40
// warm-up and fill steps plus a discarded draw. A generator that has collapsed
// to zero is refilled from one in the same way, but with no discarded draw.
// Reset clears the handshake state and marks the table for refill; the table
// itself is not cleared. A result waits in the output register while the
// receiver stalls, and the next request is already taken meanwhile.
// ============================================================================
module shuffled_lehmer_random_generator
    import slrg_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  t_req              i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output t_rsp              o_out_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [VAL_W-1:0]  r_seed;
    logic              cfg_wr;
    logic              seed_wr;
    logic [ADDR_W-3:0] reg_idx;
    t_dp_cmd           cmd;
    t_dp_sts           sts;

    // Configuration port: one seed register at byte address zero.
    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign seed_wr = cfg_wr && (reg_idx == REG_SEED);
    assign prdata  = (reg_idx == REG_SEED) ? {1'b0, r_seed} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed <= '0;
        end else if (seed_wr) begin
            r_seed <= pwdata[VAL_W-1:0];
        end
    end

    slrg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_ready (i_out_ready),
        .i_seed_wr   (seed_wr),
        .i_sts       (sts),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    slrg_dp u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .i_req  (i_in_data),
        .i_seed (r_seed),
        .o_sts  (sts),
        .o_rsp  (o_out_data)
    );

endmodule

// File: sv/slrg_dp.sv
// ============================================================================
// slrg_dp
// Datapath: Lehmer step unit, shuffle table memory and ranged-draw scaler.
// ============================================================================
module slrg_dp
    import slrg_pkg::*;
(
    input  logic             i_clk,
    input  t_dp_cmd          i_cmd,
    input  t_req             i_req,
    input  logic [VAL_W-1:0] i_seed,
    output t_dp_sts          o_sts,
    output t_rsp             o_rsp
);

    // Generator registers.
    logic [VAL_W-1:0]  r_state;
    logic [PROD_W-1:0] r_prod;
    logic [VAL_W-1:0]  r_last;
    logic [VAL_W-1:0]  r_rd;
    logic [IDX_W-1:0]  r_slot;

    // Shuffle table.
    logic [VAL_W-1:0]  mem [TABLE_DEPTH];

    // Scaler registers.
    logic               r_mode;
    logic               r_neg;
    logic signed [31:0] r_min;
    logic [31:0]        r_hi;
    logic [62:0]        r_ph;
    logic [VAL_W-1:0]   r_pl;
    logic [63:0]        r_t;
    logic [32:0]        r_a;
    logic [33:0]        r_c;
    logic [31:0]        r_q;
    t_rsp               r_rsp;

    logic [VAL_W:0]     fold;
    logic [VAL_W:0]     fold_sub;
    logic [VAL_W-1:0]   red_val;
    logic [IDX_W-1:0]   slot_sel;
    logic [VAL_W-1:0]   start_val;
    logic [32:0]        diff;
    logic [15:0]        lo_sel;
    logic [46:0]        lo_prod;
    logic [2:0]         c_hi;
    logic [31:0]        c_sum;
    logic               c_corr;

    // Modular reduction of the registered product: 2^31 folds back as 1,
    // and one conditional subtract finishes it.
    always_comb begin
        fold     = {1'b0, r_prod[VAL_W-1:0]} + (VAL_W+1)'(r_prod[PROD_W-1:VAL_W]);
        fold_sub = fold - {1'b0, LEH_M};
        red_val  = (fold >= {1'b0, LEH_M}) ? fold_sub[VAL_W-1:0] : fold[VAL_W-1:0];
    end

    // The table slot is the top bits of the last output.
    assign slot_sel  = r_last[VAL_W-1:SLOT_SHIFT];
    assign start_val = (i_cmd.use_one || i_seed == '0) ? VAL_W'(1) : i_seed;

    // Generator state and product register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_start) begin
            r_state <= start_val;
        end else if (i_cmd.step_red || i_cmd.draw_wr) begin
            r_state <= red_val;
        end
        if (i_cmd.step_mul || i_cmd.draw_rd) begin
            r_prod <= PROD_W'(r_state) * PROD_W'(LEH_A);
        end
    end

    // Shuffle table: one write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_cmd.fill_wr) begin
            mem[i_cmd.fill_idx] <= red_val;
        end else if (i_cmd.draw_wr) begin
            mem[r_slot] <= red_val;
        end
        if (i_cmd.draw_rd) begin
            r_rd   <= mem[slot_sel];
            r_slot <= slot_sel;
        end
    end

    // Last output follows table entry zero at the end of a fill, and the
    // entry read out on a draw.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_last) begin
            r_last <= red_val;
        end else if (i_cmd.draw_wr) begin
            r_last <= r_rd;
        end
    end

    assign o_sts.state_zero = (r_state == '0);
    assign o_sts.last_zero  = (r_last == '0);

    // Span of the ranged draw. A negative span is scaled by its magnitude,
    // whose whole part is the inverted difference.
    assign diff = {i_req.range_max[31], i_req.range_max}
                - {i_req.range_min[31], i_req.range_min};

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_mode <= i_req.mode;
            r_min  <= i_req.range_min;
            r_neg  <= diff[32];
            r_hi   <= diff[32] ? ~diff[31:0] : diff[31:0];
        end
    end

    // Scaled product: whole part times the draw plus the Q16 part.
    assign lo_sel  = r_neg ? LO_NEG : LO_POS;
    assign lo_prod = 47'(lo_sel) * 47'(r_last);

    // Division by 2^31-1: t = a*2^31 + b gives q = a + floor((a+b)/M),
    // and the second fold is settled by one compare.
    assign c_hi   = r_c[33:31];
    assign c_sum  = 32'(c_hi) + 32'(r_c[30:0]);
    assign c_corr = (c_sum >= {1'b0, LEH_M});

    always_ff @(posedge i_clk) begin
        if (i_cmd.sc_mul) begin
            r_ph <= 63'(r_hi) * 63'(r_last);
            r_pl <= lo_prod[46:16];
        end
        if (i_cmd.sc_sum) begin
            r_t <= 64'(r_ph) + 64'(r_pl);
        end
        if (i_cmd.sc_fold) begin
            r_a <= r_t[63:31];
            r_c <= 34'(r_t[63:31]) + 34'(r_t[30:0]);
        end
        if (i_cmd.sc_quot) begin
            r_q <= 32'(r_a + 33'(c_hi) + 33'(c_corr));
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_rsp.unit_value   <= r_last;
            r_rsp.ranged_value <= r_mode ? (r_min + (r_neg ? ~r_q : r_q)) : 32'sd0;
        end
    end

    assign o_rsp = r_rsp;

endmodule

// File: sv/slrg_ctrl.sv
// ============================================================================
// slrg_ctrl
// Controller: sequences table fill, shuffled draw and ranged scaling.
// ============================================================================
module slrg_ctrl
    import slrg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_out_ready,
    input  logic    i_seed_wr,
    input  t_dp_sts i_sts,
    output logic    o_in_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    t_state           r_st, n_st;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_init_pend, n_init_pend;
    logic             r_init_fill, n_init_fill;
    logic             r_discard, n_discard;
    logic             r_out_valid, n_out_valid;
    logic             in_xfer;

    assign o_in_ready  = (r_st == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_xfer     = i_in_valid && o_in_ready;

    // Next-state and command logic.
    always_comb begin
        n_st        = r_st;
        n_cnt       = r_cnt;
        n_init_pend = r_init_pend;
        n_init_fill = r_init_fill;
        n_discard   = r_discard;
        n_out_valid = r_out_valid;
        o_cmd       = '0;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_st)
            S_IDLE: begin
                if (in_xfer) begin
                    o_cmd.capture = 1'b1;
                    if (r_init_pend) begin
                        o_cmd.load_start = 1'b1;
                        n_cnt            = CNT_W'(FILL_STEPS - 1);
                        n_init_fill      = 1'b1;
                        n_st             = S_FMUL;
                    end else begin
                        n_st = S_CHECK;
                    end
                end
            end
            S_CHECK: begin
                // A generator stuck at zero is restarted from one.
                if (i_sts.state_zero || i_sts.last_zero) begin
                    o_cmd.load_start = 1'b1;
                    o_cmd.use_one    = 1'b1;
                    n_cnt            = CNT_W'(FILL_STEPS - 1);
                    n_init_fill      = 1'b0;
                    n_st             = S_FMUL;
                end else begin
                    n_discard = 1'b0;
                    n_st      = S_DRD;
                end
            end
            S_FMUL: begin
                o_cmd.step_mul = 1'b1;
                n_st           = S_FRED;
            end
            S_FRED: begin
                o_cmd.step_red = 1'b1;
                if (r_cnt < CNT_W'(TABLE_DEPTH)) begin
                    o_cmd.fill_wr  = 1'b1;
                    o_cmd.fill_idx = r_cnt[IDX_W-1:0];
                end
                if (r_cnt == '0) begin
                    o_cmd.set_last = 1'b1;
                    n_discard      = r_init_fill;
                    n_st           = S_DRD;
                end else begin
                    n_cnt = r_cnt - CNT_W'(1);
                    n_st  = S_FMUL;
                end
            end
            S_DRD: begin
                o_cmd.draw_rd = 1'b1;
                n_st          = S_DWR;
            end
            S_DWR: begin
                o_cmd.draw_wr = 1'b1;
                if (r_discard) begin
                    // The first draw after seeding is thrown away.
                    n_init_pend = 1'b0;
                    n_discard   = 1'b0;
                    n_st        = S_CHECK;
                end else begin
                    n_st = S_M1;
                end
            end
            S_M1: begin
                o_cmd.sc_mul = 1'b1;
                n_st         = S_M2;
            end
            S_M2: begin
                o_cmd.sc_sum = 1'b1;
                n_st         = S_M3;
            end
            S_M3: begin
                o_cmd.sc_fold = 1'b1;
                n_st          = S_M4;
            end
            S_M4: begin
                o_cmd.sc_quot = 1'b1;
                n_st          = S_OUT;
            end
            S_OUT: begin
                // Wait here only while an earlier result is still stalled.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_st           = S_IDLE;
                end
            end
            default: begin
                n_st = S_IDLE;
            end
        endcase

        if (i_seed_wr) begin
            n_init_pend = 1'b1;
        end
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st        <= S_IDLE;
            r_cnt       <= '0;
            r_init_pend <= 1'b1;
            r_init_fill <= 1'b0;
            r_discard   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_st        <= n_st;
            r_cnt       <= n_cnt;
            r_init_pend <= n_init_pend;
            r_init_fill <= n_init_fill;
            r_discard   <= n_discard;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// File: sv/slrg_chk.sv
// ============================================================================
// slrg_chk
// Port-level checker for the shuffled Lehmer generator, bound to the top.
// ============================================================================
`include "assert_macros.svh"

module slrg_chk
    import slrg_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_rsp o_out_data,
    input logic pready
);

    // A stalled result stays offered and unchanged.
    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_data)), "result dropped or changed while stalled")

    // The configuration port never inserts wait states.
    `ASSERT_CLK(a_pready, i_clk, i_rst_n, pready, "pready low")

    // A delivered unit value lies strictly between zero and the modulus.
    `ASSERT_CLK(a_unit_range, i_clk, i_rst_n, o_out_valid |-> (o_out_data.unit_value != 31'd0 && o_out_data.unit_value != LEH_M), "unit value out of range")

    // Requests are served one at a time.
    `ASSERT_CLK(a_one_item, i_clk, i_rst_n, (i_in_valid && o_in_ready) |=> !o_in_ready, "request taken while another is in flight")

    // Reset leaves no result on offer.
    `ASSERT_ALWAYS(a_reset_quiet, i_clk, !i_rst_n |=> !o_out_valid, "result valid after reset")

endmodule

bind shuffled_lehmer_random_generator slrg_chk u_chk (.*);

// File: verif/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the shuffled Lehmer random generator. Requests are
// sent over the valid/ready input channel with random gaps, and every result
// is compared field by field with a bit-exact predictor of the generator,
// its shuffle table and the ranged scaler. The seed register is written over
// the APB port between phases, including zero, the largest seed, the seed
// that collapses the generator, and a write to an unused address.
// ============================================================================
module testbench;
    import slrg_pkg::*;

    // Arithmetic constants of the generator and the ranged scaler.
    localparam longint MODULUS      = 64'd2147483647;
    localparam longint MULTIPLIER   = 64'd16807;
    localparam longint SCHRAGE_Q    = 64'd127773;
    localparam longint SCHRAGE_R    = 64'd2836;
    localparam longint SLOT_DIV     = 1 + (MODULUS - 1) / TABLE_DEPTH;
    localparam longint NEAR_ONE_Q16 = 64'd65529;

    // Register addresses, bench knobs.
    localparam logic [ADDR_W-1:0] SEED_ADDR  = {REG_SEED, 2'b00};
    localparam logic [ADDR_W-1:0] STRAY_ADDR = ADDR_W'(4);
    localparam int IDLE_PERCENT  = 32;
    localparam int MAX_SHOWN     = 10;
    localparam int DRAIN_CYCLES  = 120;
    localparam int PHASE_COUNT   = 5;
    localparam int PHASE_ITEMS   = 130;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              o_in_ready;
    t_req              i_in_data   = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    t_rsp              o_out_data;
    logic              psel        = 1'b0;
    logic              penable     = 1'b0;
    logic              pwrite      = 1'b0;
    logic [ADDR_W-1:0] paddr       = '0;
    logic [31:0]       pwdata      = '0;
    logic [31:0]       prdata;
    logic              pready;

    // Predicted generator state.
    logic [30:0] seed_reg     = '0;
    logic [30:0] gen_state    = '0;
    logic [30:0] last_draw    = '0;
    logic        init_pending = 1'b1;
    logic [30:0] shuffle_tbl [TABLE_DEPTH];

    t_rsp pending_draws [$];
    int   error_count  = 0;
    bit   stall_enable = 1'b1;

    shuffled_lehmer_random_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Free-running clock, 20 ns period.
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // One Lehmer step, state * 16807 mod 2^31-1 by Schrage's decomposition.
    function automatic logic [30:0] lehmer_advance(input logic [30:0] s);
        longint x;
        longint k;
        longint t;
        x = longint'(s);
        k = x / SCHRAGE_Q;
        t = MULTIPLIER * (x - k * SCHRAGE_Q) - SCHRAGE_R * k;
        if (t < 0) begin
            t = t + MODULUS;
        end
        return t[30:0];
    endfunction

    // Warm up eight steps, then fill the table from the top entry down.
    function automatic void refill_table(input logic [30:0] start);
        logic [30:0] s;
        s = start;
        for (int j = TABLE_DEPTH + 7; j >= 0; j--) begin
            s = lehmer_advance(s);
            if (j < TABLE_DEPTH) begin
                shuffle_tbl[j] = s;
            end
        end
        gen_state = s;
        last_draw = shuffle_tbl[0];
    endfunction

    // Bays-Durham draw: the previous output picks the slot to hand out.
    function automatic logic [30:0] shuffle_pick();
        longint slot;
        gen_state = lehmer_advance(gen_state);
        slot = longint'(last_draw) / SLOT_DIV;
        if (slot >= TABLE_DEPTH) begin
            slot = TABLE_DEPTH - 1;
        end
        last_draw = shuffle_tbl[slot];
        shuffle_tbl[slot] = gen_state;
        return last_draw;
    endfunction

    // floor(mag * u / (65536 * (2^31-1))), exact.
    function automatic longint unsigned scale_span(input longint unsigned mag,
                                                   input logic [30:0] u);
        longint unsigned hi;
        longint unsigned lo;
        longint unsigned t;
        hi = mag >> 16;
        lo = mag & 64'hFFFF;
        t  = hi * u + ((lo * u) >> 16);
        return t / MODULUS;
    endfunction

    // Expected result of one request, advancing the predicted state.
    function automatic t_rsp predict_draw(input t_req r);
        t_rsp            res;
        logic [30:0]     u;
        longint          smin;
        longint          smax;
        longint          q16;
        longint unsigned amt;
        logic [31:0]     add;
        if (init_pending) begin
            refill_table(seed_reg != 0 ? seed_reg : 31'd1);
            void'(shuffle_pick());
            init_pending = 1'b0;
        end
        // A collapsed generator restarts from one without a discarded draw.
        if (gen_state == 0 || last_draw == 0) begin
            refill_table(31'd1);
        end
        u = shuffle_pick();
        res.unit_value   = u;
        res.ranged_value = '0;
        if (r.mode) begin
            smin = {{32{r.range_min[31]}}, r.range_min};
            smax = {{32{r.range_max[31]}}, r.range_max};
            q16  = (smax - smin) * 65536 + NEAR_ONE_Q16;
            if (q16 >= 0) begin
                add = 32'(scale_span(q16, u));
            end else begin
                // Negative span rounds away from zero by one step.
                amt = scale_span(-q16, u) + 1;
                add = 32'd0 - 32'(amt);
            end
            res.ranged_value = r.range_min + add;
        end
        return res;
    endfunction

    task automatic report_error(input string what, input logic [31:0] want,
                                input logic [31:0] got);
        error_count++;
        if (error_count <= MAX_SHOWN) begin
            $display("[%0t] %s: expected %h, got %h", $time, what, want, got);
        end
    endtask

    // Receiver: random back-pressure, and every result transfer is checked.
    always @(posedge i_clk) begin : result_check
        t_rsp want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_draws.size() == 0) begin
                report_error("result with no request waiting", '0, o_out_data.unit_value);
            end else begin
                want = pending_draws.pop_front();
                if (o_out_data.unit_value !== want.unit_value) begin
                    report_error("unit_value mismatch", want.unit_value,
                                 o_out_data.unit_value);
                end
                if (o_out_data.ranged_value !== want.ranged_value) begin
                    report_error("ranged_value mismatch", want.ranged_value,
                                 o_out_data.ranged_value);
                end
            end
        end
        i_out_ready <= !(stall_enable && $urandom_range(99) < IDLE_PERCENT);
    end

    // Sends one request; valid is only lowered by an idle gap or the drain.
    task automatic send_request(input t_req r);
        while (stall_enable && $urandom_range(99) < IDLE_PERCENT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= r;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        pending_draws.push_back(predict_draw(r));
    endtask

    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_draws.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) begin
            @(posedge i_clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == SEED_ADDR) begin
            seed_reg     = data[30:0];
            init_pending = 1'b1;
        end
    endtask

    function automatic t_req make_request(input logic mode, input logic [31:0] lo,
                                          input logic [31:0] hi);
        t_req r;
        r.mode      = mode;
        r.range_min = lo;
        r.range_max = hi;
        return r;
    endfunction

    function automatic logic [31:0] boundary_value();
        case ($urandom_range(0, 4))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'h0000_0000;
            3:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    // Mostly ranged draws over a mix of wide, narrow, reversed and edge spans.
    function automatic t_req random_request();
        t_req        r;
        logic [31:0] base;
        base        = $urandom;
        r.mode      = ($urandom_range(0, 3) != 0);
        r.range_min = $urandom;
        r.range_max = $urandom;
        case ($urandom_range(0, 5))
            0, 1: begin
            end
            2: begin
                r.range_min = base;
                r.range_max = base + $urandom_range(0, 255);
            end
            3: begin
                r.range_max = base;
                r.range_min = base + $urandom_range(1, 255);
            end
            4: begin
                r.range_min = boundary_value();
                r.range_max = boundary_value();
            end
            default: begin
                r.range_min = $urandom_range(0, 40) - 20;
                r.range_max = r.range_min + $urandom_range(0, 1000);
            end
        endcase
        return r;
    endfunction

    // Draws from the reset seed (zero, served as one) over the span extremes.
    task automatic test_reset_seed();
        send_request(make_request(1'b0, 32'h0, 32'h0));
        send_request(make_request(1'b0, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_request(1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
        send_request(make_request(1'b1, 32'h7FFF_FFFF, 32'h8000_0000));
        send_request(make_request(1'b1, 32'h0, 32'h0));
        send_request(make_request(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_request(make_request(1'b1, 32'd5, 32'd4));
        send_request(make_request(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
        send_request(make_request(1'b1, 32'h8000_0000, 32'h8000_0000));
        send_request(make_request(1'b1, 32'd1, 32'd6));
        wait_for_results();
    endtask

    // Seed register extremes, the collapsing seed, a masked top bit and an
    // unused address that must leave the sequence alone.
    task automatic test_seed_extremes();
        apb_write(SEED_ADDR, 32'd1);
        repeat (3) send_request(random_request());
        wait_for_results();
        apb_write(SEED_ADDR, 32'h7FFF_FFFE);
        repeat (2) send_request(random_request());
        wait_for_results();
        apb_write(STRAY_ADDR, 32'h0000_1234);
        repeat (2) send_request(random_request());
        wait_for_results();
        apb_write(SEED_ADDR, 32'h7FFF_FFFF);
        send_request(make_request(1'b1, 32'h8000_0000, 32'h7FFF_FFFF));
        repeat (2) send_request(random_request());
        wait_for_results();
        apb_write(SEED_ADDR, 32'h8000_0005);
        repeat (2) send_request(random_request());
        wait_for_results();
        apb_write(SEED_ADDR, 32'd0);
        repeat (2) send_request(random_request());
        wait_for_results();
    endtask

    // Random phases, each from a fresh seed; one phase runs without gaps.
    task automatic test_random_draws();
        for (int p = 0; p < PHASE_COUNT; p++) begin
            stall_enable = (p != 2);
            if (p == 1) begin
                apb_write(SEED_ADDR, $urandom_range(0, 1000));
            end else begin
                apb_write(SEED_ADDR, $urandom);
            end
            repeat (PHASE_ITEMS) send_request(random_request());
            wait_for_results();
        end
        stall_enable = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_seed();
        test_seed_extremes();
        test_random_draws();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (pending_draws.size() != 0) begin
            report_error("requests left without a result", '0, pending_draws.size());
        end
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #10_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
+incdir+sv
sv/slrg_pkg.sv
sv/slrg_dp.sv
sv/slrg_ctrl.sv
sv/shuffled_lehmer_random_generator.sv
sv/slrg_chk.sv
verif/testbench.sv
